### design/indexed_list_engine_top_macros.svh
// Assertion macros for the indexed list engine.
// Used by indexed_list_engine_top; needs a signal named clock and one named reset.
`ifndef INDEXED_LIST_ENGINE_TOP_MACROS_SVH
`define INDEXED_LIST_ENGINE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ile_pkg.sv
// Shared types and constants of the indexed list engine.
// Used by ile_cell, indexed_list_engine_top and the testbench; depends on nothing.
package ile_pkg;

   localparam int CAPACITY_DEFAULT      = 64;
   localparam int ELEMENT_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      OP_APPEND = 3'd0,
      OP_INSERT = 3'd1,
      OP_GET    = 3'd2,
      OP_SET    = 3'd3,
      OP_REMOVE = 3'd4,
      OP_POP    = 3'd5,
      OP_FIND   = 3'd6,
      OP_CLEAR  = 3'd7
   } ile_op_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]  op;
      logic [6:0]  position_in;
      logic [31:0] element;
   } ile_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] data_out;
      logic        found;
      logic [5:0]  found_position;
      logic [6:0]  length;
      logic        is_empty;
   } ile_rsp_type;

   // Control part of the token that walks down the chain of cells.
   typedef struct packed {
      logic       valid;
      ile_op_type op;
      logic [6:0] pos;
      logic       act;   // The operation passed its checks and may change entries.
      logic       hit;   // A find has already matched in an earlier cell.
   } ile_ctl_type;

endpackage

### design/ile_cell.sv
// One cell of the list: holds the entry at index INDEX and one stage of the token.
// Depends on ile_pkg.
module ile_cell #(
   parameter int INDEX         = 0,
   parameter int CAPACITY      = ile_pkg::CAPACITY_DEFAULT,
   parameter int ELEMENT_WIDTH = ile_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ile_pkg::ile_ctl_type              ctl_i,
   input  logic [$clog2(CAPACITY+1)-1:0]     count_i,
   input  logic [ELEMENT_WIDTH-1:0]          elem_i,
   input  logic [ELEMENT_WIDTH-1:0]          carry_i,
   input  logic [ELEMENT_WIDTH-1:0]          data_i,
   input  logic [$clog2(CAPACITY)-1:0]       hit_pos_i,
   input  logic [ELEMENT_WIDTH-1:0]          next_entry_i,
   output ile_pkg::ile_ctl_type              ctl_o,
   output logic [$clog2(CAPACITY+1)-1:0]     count_o,
   output logic [ELEMENT_WIDTH-1:0]          elem_o,
   output logic [ELEMENT_WIDTH-1:0]          carry_o,
   output logic [ELEMENT_WIDTH-1:0]          data_o,
   output logic [$clog2(CAPACITY)-1:0]       hit_pos_o,
   output logic [ELEMENT_WIDTH-1:0]          entry_o
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   ile_pkg::ile_ctl_type       ctl_ff, ctl_in;
   logic [CNT_W-1:0]           count_ff;
   logic [ELEMENT_WIDTH-1:0]   elem_ff;
   logic [ELEMENT_WIDTH-1:0]   carry_ff, carry_in;
   logic [ELEMENT_WIDTH-1:0]   data_ff, data_in;
   logic [IDX_W-1:0]           hit_pos_ff, hit_pos_in;
   logic [ELEMENT_WIDTH-1:0]   entry_ff, entry_in;

   logic [CMP_W-1:0] k_ext, pos_ext, cnt_ext, tgt_ext;

   assign k_ext   = CMP_W'(INDEX);
   assign pos_ext = CMP_W'(ctl_i.pos);
   assign cnt_ext = CMP_W'(count_i);
   // An append is an insert at the current end of the list.
   assign tgt_ext = (ctl_i.op == ile_pkg::OP_APPEND) ? cnt_ext : pos_ext;

   always_comb begin
      ctl_in     = ctl_i;
      carry_in   = carry_i;
      data_in    = data_i;
      hit_pos_in = hit_pos_i;
      entry_in   = entry_ff;
      if (ctl_i.valid) begin
         unique case (ctl_i.op)
            ile_pkg::OP_APPEND, ile_pkg::OP_INSERT: begin
               // Every cell at or past the target takes the word from its left and
               // passes its old word on, so the list opens a gap and fills it.
               if (ctl_i.act && (k_ext >= tgt_ext)) begin
                  entry_in = carry_i;
                  carry_in = entry_ff;
               end
            end
            ile_pkg::OP_GET: begin
               if (k_ext == pos_ext) begin
                  data_in = entry_ff;
               end
            end
            ile_pkg::OP_SET: begin
               if (ctl_i.act && (k_ext == pos_ext)) begin
                  entry_in = elem_i;
               end
            end
            ile_pkg::OP_REMOVE, ile_pkg::OP_POP: begin
               if (k_ext == pos_ext) begin
                  data_in = entry_ff;
               end
               // The right neighbor has not been reached yet, so it still holds its old word.
               if (ctl_i.act && (k_ext >= pos_ext)) begin
                  entry_in = next_entry_i;
               end
            end
            ile_pkg::OP_FIND: begin
               if (!ctl_i.hit && (k_ext < cnt_ext) && (entry_ff == elem_i)) begin
                  ctl_in.hit = 1'b1;
                  hit_pos_in = IDX_W'(INDEX);
               end
            end
            ile_pkg::OP_CLEAR: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_i;
      elem_ff    <= elem_i;
      carry_ff   <= carry_in;
      data_ff    <= data_in;
      hit_pos_ff <= hit_pos_in;
      entry_ff   <= entry_in;
   end

   assign ctl_o     = ctl_ff;
   assign count_o   = count_ff;
   assign elem_o    = elem_ff;
   assign carry_o   = carry_ff;
   assign data_o    = data_ff;
   assign hit_pos_o = hit_pos_ff;
   assign entry_o   = entry_ff;

endmodule

### design/indexed_list_engine_top.sv
// Top level of the indexed list engine: request checks, length counter and chain of cells.
// Depends on ile_pkg, ile_cell and indexed_list_engine_top_macros.svh.

// An item is taken when start is high and busy is low. It then walks through a chain of
// CAPACITY cells, one cell per clock, and each cell shifts, overwrites, reads or compares
// its own entry as the item passes. The result appears on rsp_data with rsp_strobe high
// for exactly one cycle. The result must be taken in that cycle. The strobe and the
// result are registered behind the last cell. Busy stays high from the accepting edge to
// the edge that raises the strobe, so one item is in flight at a time and a new one can
// be started while the strobe is high. The spacing of items is therefore set by the
// length of the chain. The length in the result counts the list after the operation.
`include "indexed_list_engine_top_macros.svh"

module indexed_list_engine_top #(
   parameter int CAPACITY      = ile_pkg::CAPACITY_DEFAULT,
   parameter int ELEMENT_WIDTH = ile_pkg::ELEMENT_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  ile_pkg::ile_req_type req_data,
   output logic                 rsp_strobe,
   output ile_pkg::ile_rsp_type rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

   logic                 accept;
   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_strobe_ff;
   ile_pkg::ile_rsp_type rsp_ff;

   logic [CMP_W-1:0] pos_ext, cnt_ext;
   logic             in_range, full;
   ile_pkg::ile_op_type req_op;
   logic [ELEMENT_WIDTH-1:0] req_elem;

   ile_pkg::ile_ctl_type     ctl_w     [0:CAPACITY];
   logic [CNT_W-1:0]         count_w   [0:CAPACITY];
   logic [ELEMENT_WIDTH-1:0] elem_w    [0:CAPACITY];
   logic [ELEMENT_WIDTH-1:0] carry_w   [0:CAPACITY];
   logic [ELEMENT_WIDTH-1:0] data_w    [0:CAPACITY];
   logic [IDX_W-1:0]         hit_pos_w [0:CAPACITY];
   logic [ELEMENT_WIDTH-1:0] entry_w   [0:CAPACITY-1];

   ile_pkg::ile_ctl_type last_ctl;

   assign accept   = start && !busy_ff;
   assign req_op   = ile_pkg::ile_op_type'(req_data.op);
   assign req_elem = ELEMENT_WIDTH'(req_data.element);
   assign pos_ext  = CMP_W'(req_data.position_in);
   assign cnt_ext  = CMP_W'(count_ff);
   assign in_range = pos_ext < cnt_ext;
   assign full     = count_ff == CNT_W'(CAPACITY);

   // Status and new length are known from the request and the length, before the cells act.
   always_comb begin
      status_in = ile_pkg::ST_OK;
      count_in  = count_ff;
      unique case (req_op)
         ile_pkg::OP_APPEND: begin
            if (full) begin
               status_in = ile_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ile_pkg::ST_RANGE;
            end else if (full) begin
               status_in = ile_pkg::ST_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ile_pkg::OP_GET, ile_pkg::OP_SET: begin
            if (!in_range) begin
               status_in = ile_pkg::ST_RANGE;
            end
         end
         ile_pkg::OP_REMOVE, ile_pkg::OP_POP: begin
            if (!in_range) begin
               status_in = ile_pkg::ST_RANGE;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         ile_pkg::OP_FIND: begin
         end
         ile_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ctl_w[0].valid = accept;
      ctl_w[0].op    = req_op;
      ctl_w[0].pos   = req_data.position_in;
      ctl_w[0].act   = status_in == ile_pkg::ST_OK;
      ctl_w[0].hit   = 1'b0;
   end

   assign count_w[0]   = count_ff;
   assign elem_w[0]    = req_elem;
   assign carry_w[0]   = req_elem;
   assign data_w[0]    = '0;
   assign hit_pos_w[0] = '0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] next_entry;
      if (k == CAPACITY - 1) begin : g_last
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = entry_w[k+1];
      end

      ile_cell #(
         .INDEX        (k),
         .CAPACITY     (CAPACITY),
         .ELEMENT_WIDTH(ELEMENT_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl_i       (ctl_w[k]),
         .count_i     (count_w[k]),
         .elem_i      (elem_w[k]),
         .carry_i     (carry_w[k]),
         .data_i      (data_w[k]),
         .hit_pos_i   (hit_pos_w[k]),
         .next_entry_i(next_entry),
         .ctl_o       (ctl_w[k+1]),
         .count_o     (count_w[k+1]),
         .elem_o      (elem_w[k+1]),
         .carry_o     (carry_w[k+1]),
         .data_o      (data_w[k+1]),
         .hit_pos_o   (hit_pos_w[k+1]),
         .entry_o     (entry_w[k])
      );
   end

   assign last_ctl = ctl_w[CAPACITY];

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (last_ctl.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_strobe_ff <= last_ctl.valid;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
      if (last_ctl.valid) begin
         rsp_ff.status <= status_ff;
         if ((status_ff == ile_pkg::ST_OK) &&
             ((last_ctl.op == ile_pkg::OP_GET) || (last_ctl.op == ile_pkg::OP_POP))) begin
            rsp_ff.data_out <= 32'(data_w[CAPACITY]);
         end else begin
            rsp_ff.data_out <= '0;
         end
         rsp_ff.found          <= last_ctl.hit;
         rsp_ff.found_position <= last_ctl.hit ? 6'(hit_pos_w[CAPACITY]) : 6'd0;
         rsp_ff.length         <= 7'(count_ff);
         rsp_ff.is_empty       <= count_ff == '0;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `ILE_ASSERT_NEXT(a_accept_sets_busy, accept, busy_ff, "busy not raised after a word was taken")
   `ILE_ASSERT_NEXT(a_strobe_single, rsp_strobe_ff, !rsp_strobe_ff, "result strobe held longer than one cycle")
   `ILE_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CNT_W'(CAPACITY), "length exceeds capacity")
   `ILE_ASSERT_SAME(a_error_no_data, rsp_strobe_ff && (rsp_ff.status != ile_pkg::ST_OK), rsp_ff.data_out == '0, "failed operation returned data")

endmodule

### dv/tb_indexed_list_engine_top.sv
// Self-checking testbench for indexed_list_engine_top: directed corner requests, then random
// grow, shrink and mixed traffic, each result checked against a list predictor in the bench.
// Depends on ile_pkg and the RTL of the indexed list engine; reads no files.
module tb_indexed_list_engine_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ile_pkg::*;

   localparam int LIST_CAP    = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_WORDS = 135;

   typedef enum {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_type;

   // Shadow copy of the list; each accepted request word queues the result it must produce.
   class list_shadow_type;
      logic [31:0] slots [LIST_CAP];
      int unsigned used = 0;
      ile_rsp_type awaited [$];
      int failures = 0;
      int words_taken = 0;
      int results_seen = 0;
      int full_rejects = 0;
      int range_rejects = 0;
      int find_hits = 0;

      function int pending();
         return awaited.size();
      endfunction

      function void report(string what);
         failures++;
         if (failures <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
      endfunction

      function void take_request(ile_req_type w);
         ile_rsp_type r;
         ile_op_type op;
         int unsigned at;
         bit searching;
         op = ile_op_type'(w.op);
         at = w.position_in;
         r = '0;
         words_taken++;
         case (op)
            OP_APPEND: begin
               if (used >= LIST_CAP) begin
                  r.status = ST_FULL;
               end else begin
                  slots[used] = w.element;
                  used++;
               end
            end
            OP_INSERT: begin
               if (at > used) begin
                  r.status = ST_RANGE;
               end else if (used >= LIST_CAP) begin
                  r.status = ST_FULL;
               end else begin
                  for (int k = used; k > at; k--) slots[k] = slots[k-1];
                  slots[at] = w.element;
                  used++;
               end
            end
            OP_GET: begin
               if (at >= used) r.status = ST_RANGE;
               else r.data_out = slots[at];
            end
            OP_SET: begin
               if (at >= used) r.status = ST_RANGE;
               else slots[at] = w.element;
            end
            OP_REMOVE, OP_POP: begin
               if (at >= used) begin
                  r.status = ST_RANGE;
               end else begin
                  if (op == OP_POP) r.data_out = slots[at];
                  for (int k = at; k + 1 < used; k++) slots[k] = slots[k+1];
                  used--;
               end
            end
            OP_FIND: begin
               searching = 1'b1;
               for (int k = 0; k < used; k++) begin
                  if (searching && slots[k] == w.element) begin
                     r.found = 1'b1;
                     r.found_position = k[5:0];
                     searching = 1'b0;
                  end
               end
               if (r.found) find_hits++;
            end
            OP_CLEAR: begin
               used = 0;
            end
         endcase
         if (r.status == ST_FULL) full_rejects++;
         if (r.status == ST_RANGE) range_rejects++;
         r.length = used[6:0];
         r.is_empty = (used == 0);
         awaited.push_back(r);
      endfunction

      function void check_response(ile_rsp_type got);
         ile_rsp_type e;
         results_seen++;
         if (awaited.size() == 0) begin
            report($sformatf("result word with nothing expected: %h", got));
            return;
         end
         e = awaited.pop_front();
         if (got.status !== e.status)
            report($sformatf("status exp %0d got %0d", e.status, got.status));
         if (got.data_out !== e.data_out)
            report($sformatf("data_out exp %h got %h", e.data_out, got.data_out));
         if (got.found !== e.found)
            report($sformatf("found exp %0d got %0d", e.found, got.found));
         if (got.found_position !== e.found_position)
            report($sformatf("found_position exp %0d got %0d",
                             e.found_position, got.found_position));
         if (got.length !== e.length)
            report($sformatf("length exp %0d got %0d", e.length, got.length));
         if (got.is_empty !== e.is_empty)
            report($sformatf("is_empty exp %0d got %0d", e.is_empty, got.is_empty));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ile_req_type req_data = '0;
   logic        rsp_strobe;
   ile_rsp_type rsp_data;

   list_shadow_type board = new();
   int sender_idle_pct = 0;
   int cycles = 0;

   indexed_list_engine_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_response(rsp_data);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic ile_req_type make_word(ile_op_type op, int unsigned at,
                                             logic [31:0] value);
      ile_req_type w;
      w.op = op;
      w.position_in = at[6:0];
      w.element = value;
      return w;
   endfunction

   // Mostly positions inside the list, with the boundary and wild values mixed in.
   function automatic int unsigned pick_position(bit for_insert);
      int unsigned r;
      int unsigned n;
      n = board.used;
      r = $urandom_range(9);
      if (r <= 6) begin
         if (for_insert) return $urandom_range(n);
         return (n == 0) ? 0 : $urandom_range(n - 1);
      end
      if (r == 7) return n;
      if (r == 8) return $urandom_range(127);
      case ($urandom_range(2))
         0: return 0;
         1: return (n == 0) ? 0 : n - 1;
         default: return 64;
      endcase
   endfunction

   // Elements often repeat what is stored so that finds hit, including duplicates.
   function automatic logic [31:0] pick_element();
      int unsigned r;
      r = $urandom_range(9);
      if (r <= 3 && board.used != 0) return board.slots[$urandom_range(board.used - 1)];
      if (r <= 5) return $urandom_range(7);
      if (r == 6) return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      return $urandom;
   endfunction

   function automatic ile_req_type pick_request(traffic_mix_type mix);
      int unsigned r;
      ile_op_type op;
      r = $urandom_range(99);
      case (mix)
         MIX_GROW: op = (r < 45) ? OP_APPEND : (r < 75) ? OP_INSERT : (r < 82) ? OP_GET :
                        (r < 88) ? OP_SET : (r < 91) ? OP_REMOVE : (r < 93) ? OP_POP :
                        OP_FIND;
         MIX_SHRINK: op = (r < 10) ? OP_APPEND : (r < 15) ? OP_INSERT : (r < 25) ? OP_GET :
                          (r < 35) ? OP_SET : (r < 60) ? OP_REMOVE : (r < 85) ? OP_POP :
                          (r < 97) ? OP_FIND : OP_CLEAR;
         default: op = (r < 20) ? OP_APPEND : (r < 35) ? OP_INSERT : (r < 50) ? OP_GET :
                       (r < 62) ? OP_SET : (r < 72) ? OP_REMOVE : (r < 82) ? OP_POP :
                       (r < 97) ? OP_FIND : OP_CLEAR;
      endcase
      return make_word(op, pick_position(op == OP_INSERT), pick_element());
   endfunction

   // Returns at the edge where the word was accepted, with start still high.
   task automatic send_word(input ile_req_type w);
      int hold;
      hold = 0;
      if (sender_idle_pct != 0) begin
         if ($urandom_range(7) == 0) hold = $urandom_range(80, 1);
         while ($urandom_range(99) < sender_idle_pct) hold++;
      end
      if (hold != 0) begin
         start <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      board.take_request(w);
   endtask

   // Sender pause until every queued result has come back.
   task automatic drain_results();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic run_directed();
      send_word(make_word(OP_GET, 0, 32'h0));
      send_word(make_word(OP_SET, 0, 32'h1));
      send_word(make_word(OP_REMOVE, 0, 32'h0));
      send_word(make_word(OP_POP, 0, 32'h0));
      send_word(make_word(OP_FIND, 0, 32'h0));
      send_word(make_word(OP_CLEAR, 0, 32'h0));
      send_word(make_word(OP_INSERT, 1, 32'hA5A5_5A5A));
      send_word(make_word(OP_INSERT, 0, 32'hA5A5_5A5A));
      send_word(make_word(OP_APPEND, 0, 32'hFFFF_FFFF));
      send_word(make_word(OP_APPEND, 0, 32'h0));
      send_word(make_word(OP_INSERT, 0, 32'h5));
      send_word(make_word(OP_INSERT, 4, 32'h0));
      send_word(make_word(OP_INSERT, 2, 32'h1234_5678));
      send_word(make_word(OP_FIND, 0, 32'h0));
      send_word(make_word(OP_FIND, 0, 32'hDEAD_BEEF));
      send_word(make_word(OP_GET, 64, 32'h0));
      send_word(make_word(OP_GET, 127, 32'hFFFF_FFFF));
      send_word(make_word(OP_SET, 0, 32'hFFFF_FFFF));
      send_word(make_word(OP_GET, 0, 32'h0));
      send_word(make_word(OP_POP, 0, 32'h0));
      send_word(make_word(OP_REMOVE, board.used - 1, 32'h0));
      send_word(make_word(OP_INSERT, 7, 32'h7));
      send_word(make_word(OP_CLEAR, 0, 32'h0));
      send_word(make_word(OP_APPEND, 0, 32'h1));
      send_word(make_word(OP_POP, 0, 32'h0));
      send_word(make_word(OP_APPEND, 0, 32'h2));
      send_word(make_word(OP_REMOVE, 0, 32'h0));
   endtask

   // Each phase first fills the list to capacity and pushes against it, then runs
   // random segments of growing, shrinking and mixed traffic.
   task automatic run_phase(input int budget);
      int sent;
      int seg_len;
      int extra;
      traffic_mix_type mix;
      sent = 0;
      extra = 0;
      while (extra < 6) begin
         send_word(pick_request(MIX_GROW));
         sent++;
         if (board.used == LIST_CAP) extra++;
      end
      while (sent < budget) begin
         mix = traffic_mix_type'($urandom_range(2));
         seg_len = $urandom_range(40, 20);
         for (int i = 0; i < seg_len; i++) begin
            if ($urandom_range(99) < 3) drain_results();
            send_word(pick_request(mix));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 30;
      run_directed();
      run_phase(PHASE_WORDS);
      drain_results();
      sender_idle_pct = 65;
      run_phase(PHASE_WORDS);
      drain_results();
      sender_idle_pct = 0;
      run_phase(PHASE_WORDS);
      drain_results();
      repeat (LIST_CAP + 8) @(posedge clock);
      if (board.pending() != 0) board.report("expected results left over at the end");
      $display("Sent %0d request words and checked %0d results: %0d full rejections,",
               board.words_taken, board.results_seen, board.full_rejects);
      $display("%0d out-of-range rejections and %0d finds that hit; %0d mismatches.",
               board.range_rejects, board.find_hits, board.failures);
      if (board.failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+design
design/ile_pkg.sv
design/ile_cell.sv
design/indexed_list_engine_top.sv
dv/tb_indexed_list_engine_top.sv
